[rtl/core/wit_pkg.sv]
// ----------------------------------------------------------------------------
// wit_pkg
// Item types, command and offset codes, and register constants shared by the
// watchdog / interval timer core and its testbench.
// ----------------------------------------------------------------------------
package wit_pkg;

  localparam logic [2:0] CMD_TICK      = 3'd0;
  localparam logic [2:0] CMD_READ      = 3'd1;
  localparam logic [2:0] CMD_WRITE     = 3'd2;
  localparam logic [2:0] CMD_BAD_WIDTH = 3'd3;
  localparam logic [2:0] CMD_FULL_RST  = 3'd4;
  localparam logic [2:0] CMD_INT_RST   = 3'd5;

  localparam logic [1:0] OFF_CTRL  = 2'd0;
  localparam logic [1:0] OFF_COUNT = 2'd1;
  localparam logic [1:0] OFF_RSTC  = 2'd2;
  localparam logic [1:0] OFF_RSTC_RD = 2'd3;

  localparam logic [1:0] RREQ_NONE  = 2'd0;
  localparam logic [1:0] RREQ_POWER = 2'd1;
  localparam logic [1:0] RREQ_MAN   = 2'd2;

  localparam logic [7:0] KEY_A      = 8'hA5;
  localparam logic [7:0] KEY_B      = 8'h5A;
  localparam logic [7:0] CTRL_RESET = 8'h18;
  localparam logic [7:0] RSTC_RESET = 8'h1F;

  // control_reg bits
  localparam int CTRL_OVF = 7;
  localparam int CTRL_TMS = 6;
  localparam int CTRL_TME = 5;
  // reset_control_reg bits
  localparam int RSTC_WOVF = 7;
  localparam int RSTC_RSTE = 6;
  localparam int RSTC_RSTS = 5;

  localparam int PRESC_W = 14;

  typedef struct packed {
    logic [2:0]  command;
    logic [1:0]  reg_offset;
    logic [15:0] write_word;
    logic [7:0]  tick_cycles;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       access_error;
    logic       interval_irq;
    logic [1:0] reset_request;
  } out_item_t;

  // Prescaler tap for each CKS setting: divisor is 2**shift.
  function automatic logic [3:0] div_shift(input logic [2:0] cks);
    logic [3:0] sh;
    case (cks)
      3'd0:    sh = 4'd1;
      3'd1:    sh = 4'd6;
      3'd2:    sh = 4'd7;
      3'd3:    sh = 4'd8;
      3'd4:    sh = 4'd9;
      3'd5:    sh = 4'd10;
      3'd6:    sh = 4'd12;
      default: sh = 4'd13;
    endcase
    return sh;
  endfunction

endpackage

[rtl/core/wit_stream_if.sv]
// ----------------------------------------------------------------------------
// wit_stream_if
// Valid/ready stream channel carrying one item of type T.
// ----------------------------------------------------------------------------
interface wit_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/watchdog_interval_timer_core.sv]
// ----------------------------------------------------------------------------
// watchdog_interval_timer_core
// 8-bit watchdog / interval timer with byte-read, keyed word-write registers.
// ----------------------------------------------------------------------------
// Usage: each item on the request channel is one bus event: a tick carrying
// the bus cycles elapsed, a byte read, a keyed word write, a wrong-width
// access, or a full or internal reset. Every item gives exactly one item on
// the response channel with read data, an access error flag, the interval
// interrupt pulse and any reset request raised by a watchdog overflow.
// An item is taken into an input register and processed against the timer
// registers from there. Its response is registered in the result register
// once that register is free or being taken, and response valid then rises.
// One item is accepted every cycle while the response side keeps up.
// A stalled response holds in the result register; the input register keeps
// accepting until it too is occupied, then request.ready drops.
// Reset (rst, synchronous) empties both registers and returns control to
// 0x18, count and prescaler to 0 and reset control to 0x1F.
// ----------------------------------------------------------------------------
module watchdog_interval_timer_core #(
  parameter int TICK_CYCLES_MAX = 255
) (
  input  logic         clk,
  input  logic         rst,
  wit_stream_if.sink   request,
  wit_stream_if.source response
);
  import wit_pkg::*;

  localparam logic [9:0] TICK_LIMIT = 10'(TICK_CYCLES_MAX);

  logic                s1_valid;
  in_item_t            s1_item;
  logic                res_valid;
  out_item_t           res_item;

  logic [7:0]          control_reg, control_reg_next;
  logic [7:0]          count_reg, count_reg_next;
  logic [7:0]          reset_control_reg, reset_control_reg_next;
  logic [PRESC_W-1:0]  prescaler, prescaler_next;
  out_item_t           res_next;

  logic                advance;
  logic                fire;

  logic [3:0]          sh;
  logic [PRESC_W-1:0]  mask;
  logic [7:0]          cyc;
  logic [PRESC_W-1:0]  presc_sum;
  logic [PRESC_W-1:0]  adv_full;
  logic [8:0]          cnt_sum;
  logic [7:0]          key;
  logic [7:0]          wdata;

  assign advance       = !res_valid || response.ready;
  assign fire          = s1_valid && advance;
  assign request.ready = !s1_valid || advance;

  assign response.valid = res_valid;
  assign response.data  = res_item;

  // Tick datapath
  assign sh        = div_shift(control_reg[2:0]);
  assign mask      = (PRESC_W'(1) << sh) - PRESC_W'(1);
  assign cyc       = ({2'b00, s1_item.tick_cycles} > TICK_LIMIT) ? TICK_LIMIT[7:0]
                                                                 : s1_item.tick_cycles;
  assign presc_sum = (prescaler & mask) + {{(PRESC_W-8){1'b0}}, cyc};
  assign adv_full  = presc_sum >> sh;
  assign cnt_sum   = {1'b0, count_reg} + {1'b0, adv_full[7:0]};

  assign key   = s1_item.write_word[15:8];
  assign wdata = s1_item.write_word[7:0];

  always_comb begin
    control_reg_next       = control_reg;
    count_reg_next         = count_reg;
    reset_control_reg_next = reset_control_reg;
    prescaler_next         = prescaler;
    res_next               = '0;

    case (s1_item.command)
      CMD_TICK: begin
        if (control_reg[CTRL_TME]) begin
          prescaler_next = presc_sum & mask;
          count_reg_next = cnt_sum[7:0];
          if (cnt_sum[8]) begin
            if (control_reg[CTRL_TMS]) begin
              reset_control_reg_next[RSTC_WOVF] = 1'b1;
              if (reset_control_reg[RSTC_RSTE]) begin
                res_next.reset_request = reset_control_reg[RSTC_RSTS] ? RREQ_MAN
                                                                      : RREQ_POWER;
              end else begin
                // no reset wired: fall back to idle, drop the rest of this tick
                control_reg_next = CTRL_RESET;
                count_reg_next   = '0;
              end
            end else begin
              control_reg_next[CTRL_OVF] = 1'b1;
              res_next.interval_irq      = 1'b1;
            end
          end
        end
      end
      CMD_READ: begin
        case (s1_item.reg_offset)
          OFF_CTRL:    res_next.read_data = control_reg;
          OFF_COUNT:   res_next.read_data = count_reg;
          OFF_RSTC_RD: res_next.read_data = reset_control_reg;
          default:     res_next.read_data = '0;
        endcase
      end
      CMD_WRITE: begin
        case (s1_item.reg_offset)
          OFF_CTRL: begin
            if (key == KEY_A) begin
              // OVF clears on a written 0 only
              control_reg_next = {control_reg[CTRL_OVF] & wdata[7], wdata[6:5],
                                  2'b11, wdata[2:0]};
            end else if (key == KEY_B) begin
              count_reg_next = wdata;
            end else begin
              res_next.access_error = 1'b1;
            end
          end
          OFF_RSTC: begin
            if (key == KEY_A) begin
              if (wdata == 8'h00) begin
                reset_control_reg_next[RSTC_WOVF] = 1'b0;
              end else begin
                res_next.access_error = 1'b1;
              end
            end else if (key == KEY_B) begin
              reset_control_reg_next[RSTC_RSTE] = wdata[6];
              reset_control_reg_next[RSTC_RSTS] = wdata[5];
            end else begin
              res_next.access_error = 1'b1;
            end
          end
          default: ;
        endcase
      end
      CMD_BAD_WIDTH: begin
        res_next.access_error = 1'b1;
      end
      CMD_FULL_RST: begin
        control_reg_next       = CTRL_RESET;
        count_reg_next         = '0;
        prescaler_next         = '0;
        reset_control_reg_next = RSTC_RESET;
      end
      CMD_INT_RST: begin
        control_reg_next = CTRL_RESET;
        count_reg_next   = '0;
        prescaler_next   = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid          <= 1'b0;
      res_valid         <= 1'b0;
      control_reg       <= CTRL_RESET;
      count_reg         <= '0;
      reset_control_reg <= RSTC_RESET;
      prescaler         <= '0;
    end else begin
      if (request.ready) begin
        s1_valid <= request.valid;
      end
      if (advance) begin
        res_valid <= s1_valid;
      end
      if (fire) begin
        control_reg       <= control_reg_next;
        count_reg         <= count_reg_next;
        reset_control_reg <= reset_control_reg_next;
        prescaler         <= prescaler_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (request.valid && request.ready) begin
      s1_item <= request.data;
    end
    if (fire) begin
      res_item <= res_next;
    end
  end

  // Reserved bits never lose their set value
  a_reserved_bits: assert property (@(posedge clk) disable iff (rst)
    control_reg[4:3] == 2'b11 && reset_control_reg[4:0] == 5'h1F)
    else $error("reserved register bits cleared");

  // Prescaler stays below the largest divisor
  a_presc_range: assert property (@(posedge clk) disable iff (rst)
    !prescaler[PRESC_W-1])
    else $error("prescaler out of range");

  // A tick with the timer stopped leaves the count alone
  a_stopped_tick: assert property (@(posedge clk) disable iff (rst)
    fire && s1_item.command == CMD_TICK && !control_reg[CTRL_TME]
    |=> $stable(count_reg) && $stable(prescaler))
    else $error("count moved while timer stopped");

  // Interrupt and reset request never come from the same item
  a_irq_rreq: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res_item.interval_irq && res_item.reset_request != RREQ_NONE))
    else $error("interrupt and reset request together");

  // An errored access raises no timer event
  a_err_quiet: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.access_error
    |-> !res_item.interval_irq && res_item.reset_request == RREQ_NONE)
    else $error("timer event on an errored access");

endmodule

[tb/watchdog_interval_timer_core_tb.sv]
// ----------------------------------------------------------------------------
// watchdog_interval_timer_core_tb
// Self-checking bench for the watchdog / interval timer core. Items are
// pushed on the request channel with random gaps. A scoreboard keeps its own
// copy of the timer registers and predicts each response item. Responses are
// taken with random stalls and one long hold-off, and each one is checked
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module watchdog_interval_timer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wit_pkg::*;

  localparam int TICK_MAX     = 255;
  localparam int STALL_LIMIT  = 5000;
  localparam int RANDOM_ITEMS = 500;

  // command codes the core does not define; they must give an all-zero item
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;

  class timer_scoreboard;
    logic [7:0]         ctrl;
    logic [7:0]         count;
    logic [7:0]         rstc;
    logic [PRESC_W-1:0] presc;
    out_item_t          pending_responses[$];
    int                 mismatches;

    function new();
      mismatches = 0;
      clear_all();
    endfunction

    function void clear_timer();
      ctrl  = CTRL_RESET;
      count = 8'd0;
      presc = '0;
    endfunction

    function void clear_all();
      clear_timer();
      rstc = RSTC_RESET;
    endfunction

    function int tap_bits(logic [2:0] cks);
      case (cks)
        3'd0:    return 1;
        3'd1:    return 6;
        3'd2:    return 7;
        3'd3:    return 8;
        3'd4:    return 9;
        3'd5:    return 10;
        3'd6:    return 12;
        default: return 13;
      endcase
    endfunction

    function out_item_t predict_response(in_item_t it);
      out_item_t   r;
      int unsigned sh, mask, sum, steps, cyc;
      logic [7:0]  key, val;
      r   = '0;
      key = it.write_word[15:8];
      val = it.write_word[7:0];
      case (it.command)
        CMD_TICK: begin
          if (ctrl[CTRL_TME]) begin
            sh    = tap_bits(ctrl[2:0]);
            mask  = (1 << sh) - 1;
            cyc   = (it.tick_cycles > TICK_MAX) ? TICK_MAX : it.tick_cycles;
            sum   = (presc & mask) + cyc;
            steps = sum >> sh;
            presc = PRESC_W'(sum & mask);
            if (count + steps >= 256) begin
              if (ctrl[CTRL_TMS]) begin
                rstc[RSTC_WOVF] = 1'b1;
                if (rstc[RSTC_RSTE]) begin
                  r.reset_request = rstc[RSTC_RSTS] ? RREQ_MAN : RREQ_POWER;
                  count = 8'(count + steps);
                end else begin
                  // drop the rest of this tick, keep the prescaler remainder
                  ctrl  = CTRL_RESET;
                  count = 8'd0;
                end
              end else begin
                ctrl[CTRL_OVF] = 1'b1;
                r.interval_irq = 1'b1;
                count = 8'(count + steps);
              end
            end else begin
              count = 8'(count + steps);
            end
          end
        end
        CMD_READ: begin
          case (it.reg_offset)
            OFF_CTRL:    r.read_data = ctrl;
            OFF_COUNT:   r.read_data = count;
            OFF_RSTC_RD: r.read_data = rstc;
            default:     r.read_data = 8'd0;
          endcase
        end
        CMD_WRITE: begin
          if (it.reg_offset == OFF_CTRL) begin
            if (key == KEY_A)
              ctrl = {ctrl[CTRL_OVF] & val[7], val[6:5], CTRL_RESET[4:3], val[2:0]};
            else if (key == KEY_B)
              count = val;
            else
              r.access_error = 1'b1;
          end else if (it.reg_offset == OFF_RSTC) begin
            if (key == KEY_A) begin
              if (val == 8'd0)
                rstc[RSTC_WOVF] = 1'b0;
              else
                r.access_error = 1'b1;
            end else if (key == KEY_B) begin
              rstc[RSTC_RSTE] = val[RSTC_RSTE];
              rstc[RSTC_RSTS] = val[RSTC_RSTS];
            end else begin
              r.access_error = 1'b1;
            end
          end
        end
        CMD_BAD_WIDTH: r.access_error = 1'b1;
        CMD_FULL_RST:  clear_all();
        CMD_INT_RST:   clear_timer();
        default: ;
      endcase
      return r;
    endfunction

    function void note_request(in_item_t it);
      pending_responses.push_back(predict_response(it));
    endfunction

    function void check_field(string name, logic [7:0] exp, logic [7:0] act);
      if (act !== exp) begin
        $error("%s: expected 0x%02h, got 0x%02h", name, exp, act);
        mismatches++;
      end
    endfunction

    function void check_response(out_item_t got);
      out_item_t exp;
      if (pending_responses.size() == 0) begin
        $error("response item with nothing outstanding: 0x%03h", got);
        mismatches++;
        return;
      end
      exp = pending_responses.pop_front();
      check_field("read_data", exp.read_data, got.read_data);
      check_field("access_error", 8'(exp.access_error), 8'(got.access_error));
      check_field("interval_irq", 8'(exp.interval_irq), 8'(got.interval_irq));
      check_field("reset_request", 8'(exp.reset_request), 8'(got.reset_request));
    endfunction
  endclass

  logic clk;
  logic rst;

  wit_stream_if #(.T(in_item_t))  request_ch ();
  wit_stream_if #(.T(out_item_t)) response_ch ();

  watchdog_interval_timer_core #(
    .TICK_CYCLES_MAX(TICK_MAX)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .request  (request_ch),
    .response (response_ch)
  );

  timer_scoreboard sb = new();
  bit calm;
  int sent;
  int taken;
  int quiet_cycles;
  int hold_left;
  bit held_once;

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    request_ch.valid  = 1'b0;
    request_ch.data   = '0;
    response_ch.ready = 1'b0;
  end

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver: random stalls, one long hold-off once traffic is flowing.
  always @(posedge clk) begin
    if (!rst) begin
      if (response_ch.valid && response_ch.ready) begin
        sb.check_response(response_ch.data);
        taken++;
      end
      if (hold_left > 0) begin
        hold_left--;
        response_ch.ready <= 1'b0;
      end else if (!held_once && taken >= 150) begin
        held_once = 1'b1;
        hold_left = 64;
        response_ch.ready <= 1'b0;
      end else begin
        response_ch.ready <= calm || ($urandom_range(99) >= 16);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (request_ch.valid && request_ch.ready)
        || (response_ch.valid && response_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(in_item_t it);
    while (!calm && $urandom_range(99) < 16) begin
      request_ch.valid <= 1'b0;
      @(posedge clk);
    end
    request_ch.valid <= 1'b1;
    request_ch.data  <= it;
    @(posedge clk);
    while (!request_ch.ready) @(posedge clk);
    sb.note_request(it);
    sent++;
  endtask

  task automatic send(logic [2:0] cmd, logic [1:0] off, logic [15:0] word,
                      logic [7:0] cyc);
    in_item_t it;
    it.command     = cmd;
    it.reg_offset  = off;
    it.write_word  = word;
    it.tick_cycles = cyc;
    send_item(it);
  endtask

  task automatic send_noise();
    in_item_t it;
    it = in_item_t'({$urandom, $urandom});
    send_item(it);
  endtask

  // One configure-and-run burst with random content.
  task automatic run_sequence();
    logic [7:0] cfg;
    int         n;
    cfg      = 8'($urandom);
    cfg[5]   = ($urandom_range(9) != 0);
    cfg[2:0] = ($urandom_range(3) == 0) ? 3'($urandom) : 3'($urandom_range(1));
    if ($urandom_range(2) == 0)
      send(CMD_WRITE, OFF_RSTC, {KEY_B, 8'($urandom)}, 8'($urandom));
    if ($urandom_range(3) == 0)
      send(CMD_WRITE, OFF_RSTC,
           {KEY_A, ($urandom_range(3) == 0) ? 8'($urandom) : 8'd0}, 8'($urandom));
    send(CMD_WRITE, OFF_CTRL, {KEY_A, cfg}, 8'($urandom));
    send(CMD_WRITE, OFF_CTRL,
         {KEY_B, ($urandom_range(1) == 0) ? 8'($urandom_range(200, 255)) : 8'($urandom)},
         8'($urandom));
    n = $urandom_range(3, 12);
    repeat (n) begin
      if ($urandom_range(3) == 0)
        send(CMD_READ, 2'($urandom), 16'($urandom), 8'($urandom));
      else
        send(CMD_TICK, 2'($urandom), 16'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset values and plain reads
    send(CMD_READ, OFF_CTRL, 16'h0000, 8'h00);
    send(CMD_READ, OFF_RSTC, 16'h0000, 8'h00);
    send(CMD_READ, OFF_RSTC_RD, 16'h0000, 8'h00);
    // timer disabled: tick does nothing
    send(CMD_TICK, OFF_CTRL, 16'h0000, 8'hFF);
    // writes to count and reset-control read offsets are ignored
    send(CMD_WRITE, OFF_COUNT, {KEY_A, 8'hFF}, 8'h00);
    send(CMD_WRITE, OFF_RSTC_RD, {KEY_B, 8'hFF}, 8'h00);
    // bad keys, bad value, wrong width
    send(CMD_WRITE, OFF_CTRL, 16'h0000, 8'h00);
    send(CMD_WRITE, OFF_RSTC, 16'hFFFF, 8'h00);
    send(CMD_WRITE, OFF_RSTC, {KEY_A, 8'h01}, 8'h00);
    send(CMD_BAD_WIDTH, OFF_CTRL, 16'hFFFF, 8'hFF);
    // interval mode overflow, then clear OVF and switch to the slowest tap
    send(CMD_WRITE, OFF_CTRL, {KEY_A, 8'h20}, 8'h00);
    send(CMD_WRITE, OFF_CTRL, {KEY_B, 8'hF0}, 8'h00);
    send(CMD_TICK, OFF_CTRL, 16'h0000, 8'hFF);
    send(CMD_READ, OFF_CTRL, 16'h0000, 8'h00);
    send(CMD_WRITE, OFF_CTRL, {KEY_A, 8'h27}, 8'h00);
    send(CMD_TICK, OFF_CTRL, 16'h0000, 8'hFF);
    // watchdog overflow without reset request clears the timer
    send(CMD_WRITE, OFF_CTRL, {KEY_A, 8'h60}, 8'h00);
    send(CMD_WRITE, OFF_CTRL, {KEY_B, 8'hFF}, 8'h00);
    send(CMD_TICK, OFF_CTRL, 16'h0000, 8'h05);
    send(CMD_READ, OFF_RSTC_RD, 16'h0000, 8'h00);
    send(CMD_WRITE, OFF_RSTC, {KEY_A, 8'h00}, 8'h00);
    // watchdog overflow with a manual reset request
    send(CMD_WRITE, OFF_RSTC, {KEY_B, 8'h60}, 8'h00);
    send(CMD_WRITE, OFF_CTRL, {KEY_A, 8'h60}, 8'h00);
    send(CMD_WRITE, OFF_CTRL, {KEY_B, 8'hFF}, 8'h00);
    send(CMD_TICK, OFF_CTRL, 16'h0000, 8'hFF);
    // internal reset keeps reset control, full reset does not
    send(CMD_INT_RST, OFF_CTRL, 16'h0000, 8'h00);
    send(CMD_READ, OFF_RSTC_RD, 16'h0000, 8'h00);
    send(CMD_FULL_RST, OFF_CTRL, 16'h0000, 8'h00);
    send(CMD_SPARE_A, OFF_RSTC_RD, 16'hFFFF, 8'hFF);
    send(CMD_SPARE_B, OFF_RSTC_RD, 16'hFFFF, 8'hFF);

    while (sent < RANDOM_ITEMS + 30) begin
      calm = (sent >= 250 && sent < 350);
      if ($urandom_range(99) < 70)
        run_sequence();
      else
        send_noise();
    end
    calm = 1'b0;
    request_ch.valid <= 1'b0;

    while (sb.pending_responses.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

[watchdog_interval_timer_core.f]
rtl/core/wit_pkg.sv
rtl/core/wit_stream_if.sv
rtl/core/watchdog_interval_timer_core.sv
tb/watchdog_interval_timer_core_tb.sv
